>>> rtl/kwl_pkg.sv
// Package for the keyword lexer: character codes, token kinds, result record, keyword tables.
`default_nettype none
package kwl_pkg;

   // saturation limits for lexeme length and line number
   localparam int unsigned MAX_TOKEN_LENGTH = 255;
   localparam int unsigned MAX_LINE_COUNT   = 65535;

   localparam logic [7:0]  RUN_CAP  = (MAX_TOKEN_LENGTH > 255) ? 8'd255 :
                                      8'(MAX_TOKEN_LENGTH);
   localparam logic [15:0] LINE_CAP = (MAX_LINE_COUNT > 65535) ? 16'd65535 :
                                      16'(MAX_LINE_COUNT);

   // field widths
   localparam int CHAR_W = 8;
   localparam int KIND_W = 5;
   localparam int LEN_W  = 8;
   localparam int LINE_W = 16;

   // character codes
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_NUL    = 8'h00;

   // token kinds
   localparam logic [4:0] KIND_EOI    = 5'd0;
   localparam logic [4:0] KIND_SEMI   = 5'd1;
   localparam logic [4:0] KIND_PLUS   = 5'd2;
   localparam logic [4:0] KIND_SUB    = 5'd3;
   localparam logic [4:0] KIND_TIMES  = 5'd4;
   localparam logic [4:0] KIND_DIV    = 5'd5;
   localparam logic [4:0] KIND_LP     = 5'd6;
   localparam logic [4:0] KIND_RP     = 5'd7;
   localparam logic [4:0] KIND_LT     = 5'd8;
   localparam logic [4:0] KIND_GT     = 5'd9;
   localparam logic [4:0] KIND_EQ     = 5'd10;
   localparam logic [4:0] KIND_ASSIGN = 5'd11;
   localparam logic [4:0] KIND_NUM    = 5'd12;
   localparam logic [4:0] KIND_ID     = 5'd13;
   localparam logic [4:0] KIND_KW0    = 5'd14;
   localparam logic [4:0] KIND_ERR    = 5'd20;
   localparam logic [4:0] KIND_NONE   = 5'd0;

   localparam int NUM_KW = 6;

   // one result beat
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [LEN_W-1:0]  length;
      logic [LINE_W-1:0] line;
      logic [CHAR_W-1:0] bad;
      logic              last;
   } result_type;

   // keyword lengths: if, then, while, do, begin, end
   function automatic logic [2:0] kw_len(input logic [2:0] idx);
      logic [2:0] len;
      case (idx)
         3'd0:    len = 3'd2;
         3'd1:    len = 3'd4;
         3'd2:    len = 3'd5;
         3'd3:    len = 3'd2;
         3'd4:    len = 3'd5;
         3'd5:    len = 3'd3;
         default: len = 3'd0;
      endcase
      return len;
   endfunction

   // character at position pos of keyword idx, zero past its end
   function automatic logic [7:0] kw_char(input logic [2:0] idx, input logic [2:0] pos);
      logic [39:0] word;
      logic [7:0]  ch;
      case (idx)
         3'd0:    word = {"if", 24'd0};
         3'd1:    word = {"then", 8'd0};
         3'd2:    word = "while";
         3'd3:    word = {"do", 24'd0};
         3'd4:    word = "begin";
         3'd5:    word = {"end", 16'd0};
         default: word = 40'd0;
      endcase
      if (pos > 3'd4) begin
         ch = 8'd0;
      end else begin
         ch = word[8*(4-int'(pos)) +: 8];
      end
      return ch;
   endfunction

   // single-character operator kind, KIND_NONE when not an operator
   function automatic logic [4:0] op_kind(input logic [7:0] c);
      logic [4:0] k;
      unique case (c)
         CH_SEMI:   k = KIND_SEMI;
         CH_PLUS:   k = KIND_PLUS;
         CH_MINUS:  k = KIND_SUB;
         CH_STAR:   k = KIND_TIMES;
         CH_SLASH:  k = KIND_DIV;
         CH_LPAREN: k = KIND_LP;
         CH_RPAREN: k = KIND_RP;
         CH_LT:     k = KIND_LT;
         CH_GT:     k = KIND_GT;
         CH_EQ:     k = KIND_EQ;
         default:   k = KIND_NONE;
      endcase
      return k;
   endfunction

endpackage
`default_nettype wire

>>> rtl/kwl_intf.sv
// Channel interfaces of the keyword lexer: character requests and token responses.
`default_nettype none
interface kwl_req_if
   import kwl_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_byte;
   logic              end_of_input;

   modport source (output valid, output char_byte, output end_of_input, input ready);
   modport sink   (input valid, input char_byte, input end_of_input, output ready);
endinterface

interface kwl_rsp_if
   import kwl_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] token_kind;
   logic [LEN_W-1:0]  token_length;
   logic [LINE_W-1:0] line_number;
   logic [CHAR_W-1:0] bad_char;
   logic              last_of_run;

   modport source (output valid, output token_kind, output token_length,
                   output line_number, output bad_char, output last_of_run,
                   input ready);
   modport sink   (input valid, input token_kind, input token_length,
                   input line_number, input bad_char, input last_of_run,
                   output ready);
endinterface
`default_nettype wire

>>> rtl/keyword_lexer_tokenizer.sv
// Keyword lexer top level: streaming tokenizer with a four-entry token queue.
//
// req_chan takes one source byte per beat (or an end-of-input mark); rsp_chan
// gives tokens (kind, length, line, offending byte, last-of-run flag). A byte
// causes zero, one or two tokens. Lexer state is updated in the cycle of the
// accepting edge and the tokens enter the queue at that edge, so a token is
// offered on rsp_chan, from the queue, once the tokens ahead of it are taken.
// Throughput: one byte per cycle while the queue has room. The queue holds
// four tokens and req_chan is ready while at most two are waiting, so with a
// receiver that takes a token every cycle bytes flow at full rate; only bursts
// of two-token bytes fill the queue and then hold off req_chan until tokens are taken.
// When the receiver stalls, the queue fills and req_chan drops ready; no token
// is lost or repeated. Synchronous reset empties the queue, returns the lexer
// to idle at the start of a line with the line count at zero.
`default_nettype none
module keyword_lexer_tokenizer
   import kwl_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   kwl_req_if.sink      req_chan,
   kwl_rsp_if.source    rsp_chan
);

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_NUM   = 2'd1,
      MODE_ID    = 2'd2,
      MODE_COLON = 2'd3
   } mode_type;

   // lexer state
   mode_type           mode_ff,  mode_in;
   logic [LEN_W-1:0]   run_ff,   run_in;
   logic [NUM_KW-1:0]  kw_ff,    kw_in;
   logic [LINE_W-1:0]  line_ff,  line_in;
   logic               als_ff,   als_in;
   logic               lead_ff,  lead_in;

   // token queue
   result_type         queue_ff [4];
   logic [1:0]         wr_ptr_ff, rd_ptr_ff;
   logic [2:0]         count_ff;

   result_type         res [2];
   logic [1:0]         n_res;
   logic               done;
   logic [7:0]         c;
   logic               accept;
   logic               pop;
   logic               is_digit, is_letter, is_space;
   logic [4:0]         op;

   // completes the pending run or colon
   function automatic result_type flush_tok(input mode_type   mode,
                                            input logic [7:0] run,
                                            input logic [5:0] kw,
                                            input logic [15:0] line);
      result_type r;
      r = '{kind: KIND_ID, length: run, line: line, bad: 8'd0, last: 1'b0};
      case (mode)
         MODE_NUM: begin
            r.kind = KIND_NUM;
         end
         MODE_ID: begin
            // lowest-numbered matching keyword wins
            for (int i = NUM_KW - 1; i >= 0; i--) begin
               if (kw[i] && run == {5'd0, kw_len(3'(i))}) begin
                  r.kind = 5'(KIND_KW0 + 5'(i));
               end
            end
         end
         MODE_COLON: begin
            r.kind   = KIND_ERR;
            r.length = 8'd1;
            r.bad    = CH_COLON;
         end
         default: begin
            r.kind = KIND_NONE;
         end
      endcase
      return r;
   endfunction

   assign c         = req_chan.char_byte;
   assign is_digit  = (c >= "0") && (c <= "9");
   assign is_letter = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   assign is_space  = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   assign op        = op_kind(c);

   assign req_chan.ready = (count_ff <= 3'd2);
   assign accept         = req_chan.valid && req_chan.ready;
   assign pop            = rsp_chan.valid && rsp_chan.ready;

   // next lexer state and the tokens this beat causes
   always_comb begin
      mode_in = mode_ff;
      run_in  = run_ff;
      kw_in   = kw_ff;
      line_in = line_ff;
      als_in  = als_ff;
      lead_in = lead_ff;
      res[0]  = '0;
      res[1]  = '0;
      n_res   = 2'd0;
      done    = 1'b0;

      if (req_chan.end_of_input) begin
         if (mode_ff != MODE_IDLE) begin
            res[0] = flush_tok(mode_ff, run_ff, kw_ff, line_ff);
            n_res  = 2'd1;
         end
         res[n_res[0]] = '{kind: KIND_EOI, length: 8'd0, line: line_ff, bad: 8'd0,
                           last: 1'b0};
         n_res   = n_res + 2'd1;
         mode_in = MODE_IDLE;
         run_in  = 8'd0;
         kw_in   = '0;
         als_in  = 1'b1;
         lead_in = 1'b1;
      end else if (c != CH_NUL) begin
         // new line begins
         if (als_ff) begin
            if (line_ff < LINE_CAP) begin
               line_in = line_ff + 16'd1;
            end
            als_in  = 1'b0;
            lead_in = 1'b1;
         end

         // leading white space is skipped
         if (lead_in) begin
            if (c == CH_LF) begin
               als_in = 1'b1;
               done   = 1'b1;
            end else if (is_space) begin
               done = 1'b1;
            end else begin
               lead_in = 1'b0;
            end
         end

         // extend or close a pending run
         if (!done) begin
            unique case (mode_ff)
               MODE_IDLE: begin
               end
               MODE_NUM: begin
                  if (is_digit) begin
                     run_in = (run_ff < RUN_CAP) ? run_ff + 8'd1 : run_ff;
                     done   = 1'b1;
                  end else begin
                     res[0]  = flush_tok(mode_ff, run_ff, kw_ff, line_in);
                     n_res   = 2'd1;
                     mode_in = MODE_IDLE;
                     run_in  = 8'd0;
                     kw_in   = '0;
                  end
               end
               MODE_ID: begin
                  if (is_digit || is_letter) begin
                     for (int i = 0; i < NUM_KW; i++) begin
                        if (run_ff >= {5'd0, kw_len(3'(i))} ||
                            kw_char(3'(i), run_ff[2:0]) != c) begin
                           kw_in[i] = 1'b0;
                        end
                     end
                     run_in = (run_ff < RUN_CAP) ? run_ff + 8'd1 : run_ff;
                     done   = 1'b1;
                  end else begin
                     res[0]  = flush_tok(mode_ff, run_ff, kw_ff, line_in);
                     n_res   = 2'd1;
                     mode_in = MODE_IDLE;
                     run_in  = 8'd0;
                     kw_in   = '0;
                  end
               end
               MODE_COLON: begin
                  mode_in = MODE_IDLE;
                  if (c == CH_EQ) begin
                     res[0] = '{kind: KIND_ASSIGN, length: 8'd2, line: line_in,
                                bad: 8'd0, last: 1'b0};
                     n_res  = 2'd1;
                     done   = 1'b1;
                  end else begin
                     res[0] = '{kind: KIND_ERR, length: 8'd1, line: line_in,
                                bad: CH_COLON, last: 1'b0};
                     n_res  = 2'd1;
                  end
               end
            endcase
         end

         // classify the byte itself
         if (!done) begin
            if (op != KIND_NONE) begin
               res[n_res[0]] = '{kind: op, length: 8'd1, line: line_in, bad: 8'd0,
                                 last: 1'b0};
               n_res = n_res + 2'd1;
            end else if (is_digit) begin
               mode_in = MODE_NUM;
               run_in  = 8'd1;
            end else if (is_letter) begin
               mode_in = MODE_ID;
               run_in  = 8'd1;
               for (int i = 0; i < NUM_KW; i++) begin
                  kw_in[i] = (kw_char(3'(i), 3'd0) == c);
               end
            end else if (c == CH_COLON) begin
               mode_in = MODE_COLON;
            end else if (c == CH_SPACE || c == CH_TAB) begin
               // separator
            end else if (c == CH_LF) begin
               als_in  = 1'b1;
               lead_in = 1'b1;
            end else begin
               res[n_res[0]] = '{kind: KIND_ERR, length: 8'd1, line: line_in, bad: c,
                                 last: 1'b0};
               n_res = n_res + 2'd1;
            end
         end
      end

      // flag the last token of this beat
      if (n_res == 2'd2) begin
         res[1].last = 1'b1;
      end else if (n_res == 2'd1) begin
         res[0].last = 1'b1;
      end
   end

   // lexer state and queue control
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         run_ff    <= 8'd0;
         kw_ff     <= '0;
         line_ff   <= 16'd0;
         als_ff    <= 1'b1;
         lead_ff   <= 1'b1;
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         if (accept) begin
            mode_ff   <= mode_in;
            run_ff    <= run_in;
            kw_ff     <= kw_in;
            line_ff   <= line_in;
            als_ff    <= als_in;
            lead_ff   <= lead_in;
            wr_ptr_ff <= wr_ptr_ff + n_res;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 2'd1;
         end
         count_ff <= count_ff + (accept ? {1'b0, n_res} : 3'd0) - {2'd0, pop};
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (accept && n_res != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res[0];
      end
      if (accept && n_res == 2'd2) begin
         queue_ff[wr_ptr_ff + 2'd1] <= res[1];
      end
   end

   // head of queue drives the response channel
   assign rsp_chan.valid        = (count_ff != 3'd0);
   assign rsp_chan.token_kind   = queue_ff[rd_ptr_ff].kind;
   assign rsp_chan.token_length = queue_ff[rd_ptr_ff].length;
   assign rsp_chan.line_number  = queue_ff[rd_ptr_ff].line;
   assign rsp_chan.bad_char     = queue_ff[rd_ptr_ff].bad;
   assign rsp_chan.last_of_run  = queue_ff[rd_ptr_ff].last;

endmodule
`default_nettype wire
